>>> sv/sbda_pkg.sv
`timescale 1ns / 1ps
package sbda_pkg;

	// Width of the signed input word
	localparam int DATA_WIDTH = 32;

	// Decimal digits needed for the largest magnitude, 2^(DATA_WIDTH-1)
	function automatic int count_digits(int w);
		logic [64:0] m;
		int          n;
		m = 65'd1 << (w - 1);
		n = 0;
		for (int i = 0; i < 21; i++) begin
			if (m != '0) begin
				m = m / 10;
				n++;
			end
		end
		return n;
	endfunction

	localparam int NUM_DIGITS = count_digits(DATA_WIDTH);
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);
	localparam int CHAR_W     = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

	typedef logic [3:0] digit_t;

	// Per-cycle command to every cell of the chain
	typedef struct packed {
		logic clear;
		logic dabble;
		logic dshift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

endpackage

>>> sv/signed_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Channel   Ports                  Handshake
// input     value                  taken when start is high and busy is low
// result    character, last        valid for one cycle while strobe is high
//
// For each item the magnitude shifts one bit a cycle through the chain of
// BCD cells, then the digits shift out one a cycle, with leading zeros
// dropped silently.
// The minus sign leaves the cycle after the item is taken.
// Reset clears the sequencer and the cells; results cannot be stalled.
module signed_binary_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [sbda_pkg::DATA_WIDTH-1:0] value,
	output logic                                 strobe,
	output logic [sbda_pkg::CHAR_W-1:0]          character,
	output logic                                 last
);
	import sbda_pkg::*;

	cell_ctl_t cell_ctl;
	logic      mag_msb;
	logic      carry [NUM_DIGITS+1];
	digit_t    digits [NUM_DIGITS];

	sbda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.top_digit (digits[NUM_DIGITS-1]),
		.busy      (busy),
		.cell_ctl  (cell_ctl),
		.mag_msb   (mag_msb),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	assign carry[0] = mag_msb;

	// Chain of BCD cells, least significant digit first
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		digit_t lower;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_rest
			assign lower = digits[i-1];
		end
		sbda_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.bit_in   (carry[i]),
			.digit_in (lower),
			.bit_out  (carry[i+1]),
			.digit    (digits[i])
		);
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == ASCII_MINUS) ||
			(character >= ASCII_ZERO && character <= ASCII_ZERO + CHAR_W'(9)))
		else $error("result character out of range");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (character == ASCII_MINUS) |-> !last)
		else $error("minus sign flagged as last");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("item finished without a last character");
`endif

endmodule

>>> sv/sbda_cell.sv
`timescale 1ns / 1ps
module sbda_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sbda_pkg::cell_ctl_t ctl,
	input  logic              bit_in,
	input  sbda_pkg::digit_t  digit_in,
	output logic              bit_out,
	output sbda_pkg::digit_t  digit
);
	import sbda_pkg::*;

	digit_t digit_q;
	digit_t adj;

	// Add three to a digit of five or more before it doubles
	always_comb begin
		adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
		bit_out = adj[3];
	end

	// Clear, double with carry in, or take the lower neighbour's digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.dshift) begin
			digit_q <= digit_in;
		end
	end

	assign digit = digit_q;

endmodule

>>> sv/sbda_ctrl.sv
`timescale 1ns / 1ps
module sbda_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [sbda_pkg::DATA_WIDTH-1:0] value,
	input  sbda_pkg::digit_t                     top_digit,
	output logic                                 busy,
	output sbda_pkg::cell_ctl_t                  cell_ctl,
	output logic                                 mag_msb,
	output logic                                 strobe,
	output logic [sbda_pkg::CHAR_W-1:0]          character,
	output logic                                 last
);
	import sbda_pkg::*;

	state_t                  state_q, state_d;
	logic [DATA_WIDTH-1:0]   mag_q;
	logic [CNT_W-1:0]        bit_cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic                    started_q;
	logic                    strobe_q, last_q;
	logic [CHAR_W-1:0]       char_q;

	logic                    accept;
	logic                    neg;
	logic                    emit;
	logic                    final_digit;

	assign accept      = start && (state_q == ST_IDLE);
	assign neg         = value[DATA_WIDTH-1];
	assign final_digit = (rem_q == REM_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_CONV;
			ST_CONV: if (bit_cnt_q == '0) state_d = ST_EMIT;
			ST_EMIT: if (final_digit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Cell commands and digit emission
	always_comb begin
		cell_ctl = '0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: cell_ctl.clear  = accept;
			ST_CONV: cell_ctl.dabble = 1'b1;
			ST_EMIT: begin
				cell_ctl.dshift = 1'b1;
				emit = started_q || (top_digit != '0) || final_digit;
			end
			default: cell_ctl = '0;
		endcase
	end

	assign busy    = (state_q != ST_IDLE);
	assign mag_msb = mag_q[DATA_WIDTH-1];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe_q  <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (accept && neg) || emit;
			if (accept) begin
				started_q <= 1'b0;
			end else if (emit) begin
				started_q <= 1'b1;
			end
		end
	end

	// Magnitude, counters and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q     <= neg ? (~value + 1'b1) : value;
			bit_cnt_q <= CNT_W'(DATA_WIDTH - 1);
			rem_q     <= REM_W'(NUM_DIGITS);
			char_q    <= ASCII_MINUS;
			last_q    <= 1'b0;
		end else begin
			if (state_q == ST_CONV) begin
				mag_q     <= {mag_q[DATA_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			if (state_q == ST_EMIT) begin
				rem_q  <= rem_q - 1'b1;
				char_q <= ASCII_ZERO + {2'b00, top_digit};
				last_q <= final_digit;
			end
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import sbda_pkg::*;

	localparam int W           = DATA_WIDTH;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 120;
	localparam int RANDOM_ITEMS = 445;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              lst;
	} text_char_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [W-1:0]  value;
	logic                 strobe;
	logic [CHAR_W-1:0]    character;
	logic                 last;

	text_char_t pending_chars[$];
	int         mismatch_count;
	int         items_taken;
	int         chars_seen;
	int         negatives_taken;
	int         longest_text;
	int         stalled_cycles;
	bit         idle_on;

	signed_binary_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Print one line per mismatch and count them all
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Queue the expected characters for one accepted value
	function automatic void predict_decimal_text(input logic [W-1:0] v);
		logic          neg;
		logic [W:0]    mag;
		logic [3:0]    digits[$];
		text_char_t    c;
		int            n;
		neg = v[W-1];
		mag = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
		do begin
			digits.push_back(4'(mag % 10));
			mag = mag / 10;
		end while (mag != '0);
		n = digits.size();
		if (neg) begin
			c.ch  = ASCII_MINUS;
			c.lst = 1'b0;
			pending_chars.push_back(c);
			negatives_taken++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			c.ch  = ASCII_ZERO + CHAR_W'(digits[k]);
			c.lst = (k == 0);
			pending_chars.push_back(c);
		end
		if (n + int'(neg) > longest_text)
			longest_text = n + int'(neg);
	endfunction

	// Take accepted items into the predictor and check each character
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (start && !busy) begin
				predict_decimal_text(value);
				items_taken++;
			end
			if (strobe) begin
				chars_seen++;
				if (pending_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d last %0b",
						character, last));
				end else begin
					exp_c = pending_chars.pop_front();
					if (character !== exp_c.ch)
						report_mismatch($sformatf("character %0d, expected %0d",
							character, exp_c.ch));
					if (last !== exp_c.lst)
						report_mismatch($sformatf("last %0b, expected %0b on char %0d",
							last, exp_c.lst, exp_c.ch));
				end
			end
		end
	end

	// Abort when nothing moves for too long
	initial begin
		while (stalled_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("timeout: no item or character for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one item, with random gaps, and hold it until it is taken
	task automatic send_item(input logic [W-1:0] v);
		while (idle_on && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every expected character has come
	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	task automatic test_zero;
		send_item('0);
	endtask

	task automatic test_most_negative;
		send_item({1'b1, {(W-1){1'b0}}});
		send_item({1'b1, {(W-2){1'b0}}, 1'b1});
	endtask

	task automatic test_field_extremes;
		send_item({1'b0, {(W-1){1'b1}}});
		send_item('1);
		send_item(W'(1));
	endtask

	// Walk text lengths: all nines of one to nine digits, and minus 10 to 10^9
	task automatic test_text_lengths;
		longint p;
		p = 10;
		for (int k = 1; k <= 9; k++) begin
			send_item(W'(p - 1));
			send_item(W'(-p));
			p = p * 10;
		end
	endtask

	// Pause the sender mid-stream until the block has gone quiet
	task automatic test_sender_pause;
		send_item(W'($urandom));
		send_item(W'(-$urandom_range(999)));
		drain();
		send_item(W'($urandom_range(99)));
	endtask

	// Mostly short magnitudes of either sign, some full-width words
	task automatic test_random_values;
		logic [W-1:0] v;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = !(i >= 150 && i < 300);
			if ($urandom_range(3) == 0) begin
				v = W'($urandom);
			end else begin
				v = W'($urandom) >> $urandom_range(W - 1, 1);
				if ($urandom_range(1))
					v = -v;
			end
			send_item(v);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		mismatch_count  = 0;
		items_taken     = 0;
		chars_seen      = 0;
		negatives_taken = 0;
		longest_text    = 0;
		idle_on         = 1'b1;
		start  <= 1'b0;
		value  <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero();
		test_most_negative();
		test_field_extremes();
		test_text_lengths();
		test_sender_pause();
		test_random_values();

		// Let the last text drain, then watch for stray characters
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0)
			report_mismatch($sformatf("%0d characters never arrived",
				pending_chars.size()));

		$display("converted %0d values (%0d negative) into %0d characters",
			items_taken, negatives_taken, chars_seen);
		$display("longest text %0d characters, %0d mismatches",
			longest_text, mismatch_count);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
